/* sv/frame_minmax_quantizer_assert.svh */
// assertion macros shared by the quantizer modules
`ifndef FRAME_MINMAX_QUANTIZER_ASSERT_SVH
`define FRAME_MINMAX_QUANTIZER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FMMQ_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define FMMQ_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FMMQ_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define FMMQ_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

/* sv/fmmq_pkg.sv */
// shared types and constants of the frame min/max quantizer
package fmmq_pkg;
    localparam int MAX_FRAME = 4096;
    localparam int SAMPLE_W  = 32;
    localparam int POS_W     = $clog2(MAX_FRAME);
    localparam int LEN_W     = POS_W + 1;
    localparam int ADDR_W    = POS_W + 1;
    localparam int RAM_DEPTH = 2 * MAX_FRAME;
    localparam int QV_W      = 16;
    localparam int STEP_W    = 16;
    localparam int FIELD_W   = 3;
    localparam int FPS_W     = 4;
    localparam int MAX_FIELDS = 8;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
    localparam int DIV_STEPS = QV_W;

    localparam logic [QV_W-1:0] QV_MAX = {QV_W{1'b1}};

    // register indexes
    localparam logic [1:0] REG_FRAME_LENGTH    = 2'd0;
    localparam logic [1:0] REG_FIELDS_PER_STEP = 2'd1;
    localparam logic [1:0] REG_SKIP_FIELD      = 2'd2;

    // item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef struct packed {
        logic [LEN_W-1:0]   frame_length;
        logic [FPS_W-1:0]   fields_per_step;
        logic [FIELD_W-1:0] skip_field;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
        logic [POS_W-1:0]           pixel;
        logic [FIELD_W-1:0]         field;
        logic [STEP_W-1:0]          step;
        logic                       last;
    } entry_t;
endpackage

/* sv/fmmq_ram.sv */
// generic single-write, single-read ram with registered read
module fmmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* sv/fmmq_front.sv */
// front end: accepts items, stores frames, tracks min/max, issues output jobs
`include "frame_minmax_quantizer_assert.svh"
module fmmq_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  fmmq_pkg::cfg_t                   cfg,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_kind,
    input  logic signed [fmmq_pkg::SAMPLE_W-1:0] s_sample,
    input  logic [fmmq_pkg::Q_CNT_W-1:0]     q_count,
    output logic                             push,
    output fmmq_pkg::entry_t                 push_data
);
    localparam int PW = fmmq_pkg::POS_W;
    localparam int LW = fmmq_pkg::LEN_W;
    localparam int SW = fmmq_pkg::SAMPLE_W;

    logic          bank_reg, bank_next;
    logic [PW-1:0] wpos_reg, wpos_next;
    logic [PW-1:0] rpos_reg, rpos_next;
    logic          pend_reg, pend_next;
    logic signed [SW-1:0] rmin_reg, rmin_next, rmax_reg, rmax_next;
    logic signed [SW-1:0] fmin_reg, fmin_next, fmax_reg, fmax_next;
    logic [fmmq_pkg::FIELD_W-1:0] fcnt_reg, fcnt_next, pfield_reg, pfield_next;
    logic [fmmq_pkg::STEP_W-1:0]  step_reg, step_next, pstep_reg, pstep_next;
    logic [LW-1:0] plen_reg, plen_next;
    logic          job_v_reg;
    fmmq_pkg::entry_t job_reg;

    logic          acc, emit, load, complete, last;
    logic [LW-1:0] eff_len;
    logic [PW-1:0] pos_c;
    logic [fmmq_pkg::FPS_W-1:0] fnext;
    logic [fmmq_pkg::ADDR_W-1:0] waddr, raddr;
    logic [SW-1:0] rdata;

    // room for this item and the one in flight
    assign s_ready = ({1'b0, q_count} + {{fmmq_pkg::Q_CNT_W{1'b0}}, job_v_reg})
                     < (fmmq_pkg::Q_CNT_W + 1)'(fmmq_pkg::Q_DEPTH);
    assign acc  = s_valid && s_ready;
    assign emit = acc && pend_reg;
    assign load = acc && (s_kind == fmmq_pkg::KIND_LOAD);

    // effective frame length, clamped to 1..MAX_FRAME
    always_comb begin
        if (cfg.frame_length == '0) begin
            eff_len = LW'(1);
        end else if (cfg.frame_length > LW'(fmmq_pkg::MAX_FRAME)) begin
            eff_len = LW'(fmmq_pkg::MAX_FRAME);
        end else begin
            eff_len = cfg.frame_length;
        end
    end

    assign pos_c    = ({1'b0, wpos_reg} >= eff_len) ? PW'(eff_len - LW'(1)) : wpos_reg;
    assign complete = ({1'b0, pos_c} + LW'(1)) >= eff_len;
    assign last     = ({1'b0, rpos_reg} + LW'(1)) >= plen_reg;
    assign fnext    = {1'b0, fcnt_reg} + fmmq_pkg::FPS_W'(1);
    assign waddr    = {bank_reg, pos_c};
    assign raddr    = {~bank_reg, rpos_reg};

    // frame store, two banks
    fmmq_ram #(
        .WIDTH(fmmq_pkg::SAMPLE_W),
        .DEPTH(fmmq_pkg::RAM_DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (load),
        .waddr(waddr),
        .wdata(s_sample),
        .raddr(raddr),
        .rdata(rdata)
    );

    // next state: emission first, then load and frame completion
    always_comb begin
        bank_next   = bank_reg;
        wpos_next   = wpos_reg;
        rpos_next   = rpos_reg;
        pend_next   = pend_reg;
        rmin_next   = rmin_reg;
        rmax_next   = rmax_reg;
        fmin_next   = fmin_reg;
        fmax_next   = fmax_reg;
        fcnt_next   = fcnt_reg;
        step_next   = step_reg;
        pfield_next = pfield_reg;
        pstep_next  = pstep_reg;
        plen_next   = plen_reg;
        if (emit) begin
            if (last) begin
                pend_next = 1'b0;
                rpos_next = '0;
            end else begin
                rpos_next = rpos_reg + PW'(1);
            end
        end
        if (load) begin
            if (s_sample < rmin_reg) rmin_next = s_sample;
            if (s_sample > rmax_reg) rmax_next = s_sample;
            if (complete) begin
                fmin_next   = (s_sample < rmin_reg) ? s_sample : rmin_reg;
                fmax_next   = (s_sample > rmax_reg) ? s_sample : rmax_reg;
                rmin_next   = {1'b0, {(SW-1){1'b1}}};
                rmax_next   = {1'b1, {(SW-1){1'b0}}};
                pfield_next = fcnt_reg;
                pstep_next  = step_reg;
                plen_next   = eff_len;
                pend_next   = (fcnt_reg != cfg.skip_field);
                rpos_next   = '0;
                wpos_next   = '0;
                bank_next   = ~bank_reg;
                if (fnext >= cfg.fields_per_step ||
                    fnext >= fmmq_pkg::FPS_W'(fmmq_pkg::MAX_FIELDS)) begin
                    fcnt_next = '0;
                    step_next = step_reg + fmmq_pkg::STEP_W'(1);
                end else begin
                    fcnt_next = fnext[fmmq_pkg::FIELD_W-1:0];
                end
            end else begin
                wpos_next = pos_c + PW'(1);
            end
        end
    end

    // frame state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_reg   <= 1'b0;
            wpos_reg   <= '0;
            rpos_reg   <= '0;
            pend_reg   <= 1'b0;
            rmin_reg   <= {1'b0, {(SW-1){1'b1}}};
            rmax_reg   <= {1'b1, {(SW-1){1'b0}}};
            fmin_reg   <= '0;
            fmax_reg   <= '0;
            fcnt_reg   <= '0;
            step_reg   <= '0;
            pfield_reg <= '0;
            pstep_reg  <= '0;
            plen_reg   <= '0;
            job_v_reg  <= 1'b0;
        end else begin
            bank_reg   <= bank_next;
            wpos_reg   <= wpos_next;
            rpos_reg   <= rpos_next;
            pend_reg   <= pend_next;
            rmin_reg   <= rmin_next;
            rmax_reg   <= rmax_next;
            fmin_reg   <= fmin_next;
            fmax_reg   <= fmax_next;
            fcnt_reg   <= fcnt_next;
            step_reg   <= step_next;
            pfield_reg <= pfield_next;
            pstep_reg  <= pstep_next;
            plen_reg   <= plen_next;
            job_v_reg  <= emit;
        end
    end

    // job tags are held in a register while the store read completes
    always_ff @(posedge aclk) begin
        if (emit) begin
            job_reg.sample <= '0;
            job_reg.lo     <= fmin_reg;
            job_reg.hi     <= fmax_reg;
            job_reg.pixel  <= rpos_reg;
            job_reg.field  <= pfield_reg;
            job_reg.step   <= pstep_reg;
            job_reg.last   <= last;
        end
    end

    // push job with stored sample
    always_comb begin
        push_data        = job_reg;
        push_data.sample = rdata;
    end
    assign push = job_v_reg;

    `FMMQ_ASSERT_NXT(a_wpos_cleared, aclk, aresetn, load && complete, wpos_reg == '0, "write position not cleared after frame")
endmodule

/* sv/fmmq_queue.sv */
// short job queue between front and back ends
`include "frame_minmax_quantizer_assert.svh"
module fmmq_queue (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  fmmq_pkg::entry_t             push_data,
    input  logic                         pop,
    output fmmq_pkg::entry_t             pop_data,
    output logic [fmmq_pkg::Q_CNT_W-1:0] count
);
    localparam int PTW = fmmq_pkg::Q_PTR_W;

    fmmq_pkg::entry_t slot_reg [fmmq_pkg::Q_DEPTH];
    logic [PTW-1:0] wptr_reg, rptr_reg;
    logic [fmmq_pkg::Q_CNT_W-1:0] count_reg;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) wptr_reg <= wptr_reg + PTW'(1);
            if (pop)  rptr_reg <= rptr_reg + PTW'(1);
            if (push && !pop) begin
                count_reg <= count_reg + fmmq_pkg::Q_CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - fmmq_pkg::Q_CNT_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) slot_reg[wptr_reg] <= push_data;
    end

    assign pop_data = slot_reg[rptr_reg];
    assign count    = count_reg;

    `FMMQ_ASSERT_IMP(a_no_overflow, aclk, aresetn, push && !pop, count_reg < fmmq_pkg::Q_CNT_W'(fmmq_pkg::Q_DEPTH), "queue overflow")
    `FMMQ_ASSERT_IMP(a_no_underflow, aclk, aresetn, pop, count_reg != '0, "queue underflow")
endmodule

/* sv/fmmq_back.sv */
// back end: rescales one job with a bit-serial divider and holds the result
`include "frame_minmax_quantizer_assert.svh"
module fmmq_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [fmmq_pkg::Q_CNT_W-1:0] q_count,
    input  fmmq_pkg::entry_t             q_data,
    output logic                         pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [15:0]                  m_quantized_value,
    output logic [11:0]                  m_pixel_index,
    output logic [2:0]                   m_field_number,
    output logic [15:0]                  m_step_number,
    output logic                         m_last_in_frame
);
    localparam int SW = fmmq_pkg::SAMPLE_W;
    localparam int QW = fmmq_pkg::QV_W;
    localparam int CW = $clog2(fmmq_pkg::DIV_STEPS);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_OUT} state_t;

    state_t state_reg;
    logic [SW-1:0] span_reg, rem_reg;
    logic [QW-1:0] nlo_reg, quo_reg;
    logic [CW-1:0] cnt_reg;
    logic [fmmq_pkg::POS_W-1:0]   pixel_reg;
    logic [fmmq_pkg::FIELD_W-1:0] field_reg;
    logic [fmmq_pkg::STEP_W-1:0]  step_reg;
    logic                         last_reg;

    logic [SW:0]      span_w, diff_w;
    logic             is_zero, is_full;
    logic [SW+QW-1:0] numer;
    logic [SW:0]      rem_sh;
    logic             ge;

    // operand preparation for the job at the queue head
    assign span_w  = {q_data.hi[SW-1], q_data.hi} - {q_data.lo[SW-1], q_data.lo};
    assign diff_w  = {q_data.sample[SW-1], q_data.sample} - {q_data.lo[SW-1], q_data.lo};
    assign is_zero = (q_data.hi <= q_data.lo) || (q_data.sample <= q_data.lo);
    assign is_full = diff_w[SW-1:0] >= span_w[SW-1:0];
    // diff * 65535 as a shift and subtract
    assign numer   = {diff_w[SW-1:0], {QW{1'b0}}} - {{QW{1'b0}}, diff_w[SW-1:0]};

    // one quotient bit per cycle
    assign rem_sh = {rem_reg, nlo_reg[QW-1]};
    assign ge     = rem_sh >= {1'b0, span_reg};

    assign pop = (state_reg == ST_IDLE) && (q_count != '0);

    // control and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (pop) begin
                        pixel_reg <= q_data.pixel;
                        field_reg <= q_data.field;
                        step_reg  <= q_data.step;
                        last_reg  <= q_data.last;
                        span_reg  <= span_w[SW-1:0];
                        rem_reg   <= numer[SW+QW-1:QW];
                        nlo_reg   <= numer[QW-1:0];
                        cnt_reg   <= '0;
                        if (is_zero) begin
                            quo_reg   <= '0;
                            state_reg <= ST_OUT;
                        end else if (is_full) begin
                            quo_reg   <= fmmq_pkg::QV_MAX;
                            state_reg <= ST_OUT;
                        end else begin
                            quo_reg   <= '0;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    rem_reg <= ge ? SW'(rem_sh - {1'b0, span_reg}) : rem_sh[SW-1:0];
                    nlo_reg <= {nlo_reg[QW-2:0], 1'b0};
                    quo_reg <= {quo_reg[QW-2:0], ge};
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(fmmq_pkg::DIV_STEPS - 1)) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid           = (state_reg == ST_OUT);
    assign m_quantized_value = quo_reg;
    assign m_pixel_index     = pixel_reg;
    assign m_field_number    = field_reg;
    assign m_step_number     = step_reg;
    assign m_last_in_frame   = last_reg;

    `FMMQ_ASSERT_NXT(a_div_ends, aclk, aresetn, state_reg == ST_DIV && cnt_reg == CW'(fmmq_pkg::DIV_STEPS - 1), state_reg == ST_OUT, "divider did not finish")
endmodule

/* sv/frame_minmax_quantizer.sv */
// top level of the frame min/max quantizer: register port and part wiring
// A result of 0 or 65535 bypasses the divider; any other result runs the 16-step divider.
// Throughput: one item per cycle in the front end while the 4-deep job queue has room;
// the bit-serial back end takes a new job only after its last result has been accepted.
// Reset (synchronous, aresetn low) clears frame state, queue and registers to defaults;
// the frame store is not cleared and needs no clearing pass.
module frame_minmax_quantizer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic signed [31:0] s_sample,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_quantized_value,
    output logic [11:0]        m_pixel_index,
    output logic [2:0]         m_field_number,
    output logic [15:0]        m_step_number,
    output logic               m_last_in_frame
);
    fmmq_pkg::cfg_t   cfg_reg;
    fmmq_pkg::entry_t push_data, pop_data;
    logic             push, pop, wr_en;
    logic [1:0]       reg_idx;
    logic [fmmq_pkg::Q_CNT_W-1:0] q_count;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_length    <= fmmq_pkg::LEN_W'(1225);
            cfg_reg.fields_per_step <= fmmq_pkg::FPS_W'(5);
            cfg_reg.skip_field      <= fmmq_pkg::FIELD_W'(4);
        end else if (wr_en) begin
            if (reg_idx == fmmq_pkg::REG_FRAME_LENGTH) begin
                cfg_reg.frame_length <= pwdata[fmmq_pkg::LEN_W-1:0];
            end
            if (reg_idx == fmmq_pkg::REG_FIELDS_PER_STEP) begin
                cfg_reg.fields_per_step <= pwdata[fmmq_pkg::FPS_W-1:0];
            end
            if (reg_idx == fmmq_pkg::REG_SKIP_FIELD) begin
                cfg_reg.skip_field <= pwdata[fmmq_pkg::FIELD_W-1:0];
            end
        end
    end

    // register read back
    always_comb begin
        unique case (reg_idx)
            fmmq_pkg::REG_FRAME_LENGTH:
                prdata = {{(32 - fmmq_pkg::LEN_W){1'b0}}, cfg_reg.frame_length};
            fmmq_pkg::REG_FIELDS_PER_STEP:
                prdata = {{(32 - fmmq_pkg::FPS_W){1'b0}}, cfg_reg.fields_per_step};
            fmmq_pkg::REG_SKIP_FIELD:
                prdata = {{(32 - fmmq_pkg::FIELD_W){1'b0}}, cfg_reg.skip_field};
            default:
                prdata = '0;
        endcase
    end

    fmmq_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_kind   (s_kind),
        .s_sample (s_sample),
        .q_count  (q_count),
        .push     (push),
        .push_data(push_data)
    );

    fmmq_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .pop_data (pop_data),
        .count    (q_count)
    );

    fmmq_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_count          (q_count),
        .q_data           (pop_data),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_quantized_value(m_quantized_value),
        .m_pixel_index    (m_pixel_index),
        .m_field_number   (m_field_number),
        .m_step_number    (m_step_number),
        .m_last_in_frame  (m_last_in_frame)
    );
endmodule
